[hdl/rtss_pkg.sv]
//------------------------------------------------------------------------------
// rtss_pkg
// Shared types and constants for the regression tree split search.
//------------------------------------------------------------------------------
package rtss_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 65536;
  localparam int unsigned MAX_FEATURES_DEF = 256;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_NODE_SIZE   = 1'b0,
    CFG_MIN_NODE_WEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TOTALS = 2'd0,
    OP_SCAN   = 2'd1,
    OP_EMIT   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         feature_index;
    logic [15:0]        weight;
    logic signed [15:0] target;
    logic signed [31:0] feature_value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic               is_leaf;
    logic [7:0]         split_feature;
    logic signed [31:0] split_threshold;
    logic signed [15:0] left_value;
    logic signed [15:0] right_value;
    logic [16:0]        left_count;
    logic [16:0]        right_count;
    logic [62:0]        gain;
  } out_item_t;

  // Divider request / response between sequencer and divider
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [31:0]  den;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] quo;
    logic [31:0]  rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_DIV,
    ST_SCORE,
    ST_CHECK,
    ST_MEAN_L,
    ST_MEAN_R,
    ST_MEAN_N,
    ST_TOT_DONE,
    ST_SCAN_UPD,
    ST_EMIT,
    ST_OUT
  } state_t;

  localparam logic [62:0] SCORE_MAX = {63{1'b1}};
  localparam logic signed [47:0] WY_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] WY_MIN = {1'b1, {47{1'b0}}};

endpackage

[hdl/rtss_if.sv]
//------------------------------------------------------------------------------
// rtss_if
// Valid/ready channel carrying one payload beat.
//------------------------------------------------------------------------------
interface rtss_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/rtss_div.sv]
//------------------------------------------------------------------------------
// rtss_div
// Restoring divider, 128-bit dividend by 32-bit divisor, one bit per cycle.
//------------------------------------------------------------------------------
module rtss_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rtss_pkg::div_req_t req,
  output rtss_pkg::div_rsp_t rsp
);
  import rtss_pkg::*;

  logic [127:0] quo_r, quo_nxt;
  logic [32:0]  rem_r, rem_nxt;
  logic [31:0]  den_r, den_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [32:0]  trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[127]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 8'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[126:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[126:0], 1'b0};
      end
      cnt_nxt = cnt_r + 8'd1;
      if (cnt_r == 8'd127) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[31:0];

endmodule

[hdl/regression_tree_split_search.sv]
//------------------------------------------------------------------------------
// regression_tree_split_search
// Best-split search for one regression tree node in fixed point.
//------------------------------------------------------------------------------
// One item at a time. An ignored item, a totals item that is not the last beat
// and a scan item without a candidate need no score. A totals last beat of
// nonzero weight computes one score: a square on a 17x51 multiplier, then a
// division on the shared bit-serial divider. A scan item with a candidate
// computes two scores, and two more divisions for the child means when the
// candidate wins. An emit divides for a leaf mean when the node weight is
// nonzero, not for a split, and waits while an earlier result still sits in
// the output register. Other items are taken while a result waits.
module regression_tree_split_search #(
  parameter int unsigned MAX_SAMPLES  = rtss_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned MAX_FEATURES = rtss_pkg::MAX_FEATURES_DEF,
  parameter int unsigned WEIGHT_BITS  = rtss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rtss_if.sink                            in_ch,
  rtss_if.source                          out_ch,
  input  logic                            cfg_we,
  input  logic [rtss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rtss_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [15:0] WMASK = 16'((32'd1 << WEIGHT_BITS) - 32'd1);

  // score/mean step select
  localparam logic [1:0] SEL_LEFT  = 2'd0;  // left side, or mean not started
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_NODE  = 2'd2;
  localparam logic [1:0] SEL_WAIT  = 2'd3;  // mean division running

  state_t state_r, state_nxt;

  logic [15:0] min_size_r;
  logic [31:0] min_weight_r;

  logic [31:0]        tw_r, tw_nxt;
  logic signed [47:0] twy_r, twy_nxt;
  logic [CNT_W-1:0]   tc_r, tc_nxt;
  logic [62:0]        node_score_r, node_score_nxt;
  logic [63:0]        best_score_r, best_score_nxt;
  logic               found_r, found_nxt;
  logic [7:0]         bfeat_r, bfeat_nxt;
  logic signed [31:0] bthr_r, bthr_nxt;
  logic signed [15:0] blm_r, blm_nxt;
  logic signed [15:0] brm_r, brm_nxt;
  logic [CNT_W-1:0]   blc_r, blc_nxt;
  logic [31:0]        lw_r, lw_nxt;
  logic signed [47:0] lwy_r, lwy_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic signed [31:0] prev_r, prev_nxt;

  in_item_t           item_r, item_nxt;
  logic [1:0]         sel_r, sel_nxt;
  logic [1:0]         sqc_r, sqc_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [96:0]        sq_r, sq_nxt;
  logic [50:0]        mag_r, mag_nxt;
  logic [31:0]        dw_r, dw_nxt;
  logic signed [48:0] dwy_r, dwy_nxt;
  logic signed [15:0] lm_r, lm_nxt;

  out_item_t out_r, out_nxt;
  logic      ov_r, ov_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  rtss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic               acc_in;
  logic [16:0]        wm;
  logic signed [31:0] wy_c;
  logic [32:0]        sumw;
  logic [31:0]        rw_c;
  logic signed [48:0] rwy_c;
  logic signed [32:0] xsum;
  logic signed [31:0] mid;
  logic [CNT_W:0]     kk;
  logic signed [50:0] mnum;
  logic [50:0]        mmag;
  logic               mneg;
  logic [63:0]        term;
  logic [16:0]        sq_chunk;
  logic [67:0]        sq_part;

  function automatic logic [50:0] mag_of(logic signed [48:0] v);
    logic signed [49:0] e;
    e = {v[48], v};
    return e[49] ? 51'(-e) : 51'(e);
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r   <= 16'd1;
      min_weight_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_NODE_SIZE:   min_size_r   <= cfg_wdata[15:0];
        CFG_MIN_NODE_WEIGHT: min_weight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    wm    = {1'b0, item_r.weight & WMASK};
    wy_c  = $signed({1'b0, wm[15:0]}) * item_r.target;
    sumw  = {1'b0, dw_r} + {17'd0, wm[15:0]};
    rw_c  = tw_r - lw_r;
    rwy_c = {twy_r[47], twy_r} - {lwy_r[47], lwy_r};
    xsum  = {prev_r[31], prev_r} + {item_r.feature_value[31], item_r.feature_value};
    mid   = xsum[32:1];
    kk    = {1'b0, pos_r} + {1'b0, CNT_W'(min_size_r)};
    mnum  = {dwy_r[48], dwy_r, 1'b0} + {19'd0, dw_r};
    mneg  = mnum[50];
    mmag  = mneg ? 51'(-mnum) : mnum;
    term  = {1'b0, (drsp.quo[127:63] != 0) ? SCORE_MAX : drsp.quo[62:0]};
    sq_chunk = (sqc_r == 2'd0) ? mag_r[50:34] :
               (sqc_r == 2'd1) ? mag_r[33:17] : mag_r[16:0];
    sq_part  = sq_chunk * mag_r;
  end

  // means divide |2WY+W| by W, then halve the quotient with the remainder
  always_comb begin
    state_nxt = state_r;
    tw_nxt = tw_r; twy_nxt = twy_r; tc_nxt = tc_r;
    node_score_nxt = node_score_r; best_score_nxt = best_score_r;
    found_nxt = found_r; bfeat_nxt = bfeat_r; bthr_nxt = bthr_r;
    blm_nxt = blm_r; brm_nxt = brm_r; blc_nxt = blc_r;
    lw_nxt = lw_r; lwy_nxt = lwy_r; pos_nxt = pos_r; prev_nxt = prev_r;
    item_nxt = item_r; sel_nxt = sel_r; sqc_nxt = sqc_r; acc_nxt = acc_r;
    sq_nxt = sq_r; mag_nxt = mag_r; dw_nxt = dw_r; dwy_nxt = dwy_r; lm_nxt = lm_r;
    out_nxt = out_r; ov_nxt = ov_r;
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = dw_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          item_nxt = in_ch.data;
          unique case (op_t'(in_ch.data.operation))
            OP_TOTALS: begin
              dw_nxt = tw_r; dwy_nxt = {twy_r[47], twy_r};
              state_nxt = ST_TOT_DONE;
            end
            OP_SCAN: begin
              dw_nxt = lw_r; dwy_nxt = {lwy_r[47], lwy_r};
              if (32'(in_ch.data.feature_index) >= MAX_FEATURES)
                state_nxt = ST_IDLE;
              else if (tw_r != 0 && pos_r != 0 && lw_r != 0 && lw_r < tw_r) begin
                sel_nxt = SEL_LEFT;
                acc_nxt = '0;
                mag_nxt = mag_of({lwy_r[47], lwy_r});
                state_nxt = ST_SQ_A;
              end else state_nxt = ST_SCAN_UPD;
            end
            OP_EMIT: begin
              dw_nxt = tw_r; dwy_nxt = {twy_r[47], twy_r};
              if (!found_r && tw_r != 0) state_nxt = ST_MEAN_N;
              else state_nxt = ST_EMIT;
              sel_nxt = SEL_LEFT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TOT_DONE: begin
        tw_nxt  = sumw[32] ? 32'hffff_ffff : sumw[31:0];
        begin
          logic signed [48:0] s2;
          s2 = {twy_r[47], twy_r} + 49'(wy_c);
          twy_nxt = (s2 > 49'(WY_MAX)) ? WY_MAX :
                    (s2 < 49'(WY_MIN)) ? WY_MIN : s2[47:0];
          if (tc_r < CNT_MAX) tc_nxt = tc_r + CNT_ONE;
          if (item_r.last) begin
            dw_nxt  = sumw[32] ? 32'hffff_ffff : sumw[31:0];
            mag_nxt = mag_of({twy_nxt[47], twy_nxt});
            sel_nxt = SEL_NODE;
            acc_nxt = '0;
            if (dw_nxt == 0) begin
              node_score_nxt = '0; best_score_nxt = '0; found_nxt = 1'b0;
              state_nxt = ST_IDLE;
            end else state_nxt = ST_SQ_A;
          end else state_nxt = ST_IDLE;
        end
      end
      ST_SQ_A: begin
        // square in three 17-bit slices, top slice first
        sq_nxt = ((sqc_r == 2'd0) ? 97'd0 : (sq_r << 17)) + 97'(sq_part);
        if (sqc_r == 2'd2) begin
          sqc_nxt = 2'd0;
          state_nxt = ST_DIV;
        end else sqc_nxt = sqc_r + 2'd1;
      end
      ST_DIV: begin
        dreq.start = 1'b1;
        dreq.num = {31'd0, sq_r};
        dreq.den = dw_r;
        state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        if (drsp.done) begin
          if (sel_r == SEL_NODE) begin
            node_score_nxt = term[62:0];
            best_score_nxt = term;
            found_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else if (sel_r == SEL_LEFT) begin
            acc_nxt = term;
            sel_nxt = SEL_RIGHT;
            dw_nxt = rw_c; dwy_nxt = rwy_c;
            mag_nxt = mag_of(rwy_c);
            state_nxt = ST_SQ_A;
          end else begin
            acc_nxt = acc_r + term;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (acc_r > best_score_r && pos_r >= CNT_W'(min_size_r) &&
            kk <= {1'b0, tc_r} && lw_r >= min_weight_r && rw_c >= min_weight_r &&
            mid != prev_r) begin
          found_nxt = 1'b1;
          best_score_nxt = acc_r;
          bfeat_nxt = item_r.feature_index;
          bthr_nxt = mid;
          blc_nxt = pos_r;
          dw_nxt = lw_r; dwy_nxt = {lwy_r[47], lwy_r};
          sel_nxt = SEL_LEFT;
          state_nxt = ST_MEAN_L;
        end else state_nxt = ST_SCAN_UPD;
      end
      ST_MEAN_L, ST_MEAN_R, ST_MEAN_N: begin
        if (sel_r == SEL_LEFT) begin
          dreq.start = 1'b1;
          dreq.num = {77'd0, mmag};
          dreq.den = dw_r;
          sel_nxt = SEL_WAIT;
        end else if (drsp.done) begin
          // q = floor(mmag / 2W): quotient by W halved
          sel_nxt = SEL_LEFT;
          begin
            logic signed [15:0] r;
            logic up;
            logic signed [51:0] qq;
            up = drsp.quo[0] || (drsp.rem != 0);
            qq = mneg ? -$signed({3'b0, drsp.quo[49:1]}) - (up ? 52'sd1 : 52'sd0)
                      : $signed({3'b0, drsp.quo[49:1]});
            r = (qq > 52'sd32767) ? 16'sh7fff :
                (qq < -52'sd32768) ? 16'sh8000 : qq[15:0];
            if (state_r == ST_MEAN_L) begin
              blm_nxt = r;
              dw_nxt = rw_c; dwy_nxt = rwy_c;
              state_nxt = ST_MEAN_R;
            end else if (state_r == ST_MEAN_R) begin
              brm_nxt = r;
              state_nxt = ST_SCAN_UPD;
            end else begin
              lm_nxt = r;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_SCAN_UPD: begin
        begin
          logic [32:0] s1;
          logic signed [48:0] s2;
          s1 = {1'b0, lw_r} + {17'd0, wm[15:0]};
          s2 = {lwy_r[47], lwy_r} + 49'(wy_c);
          lw_nxt = s1[32] ? 32'hffff_ffff : s1[31:0];
          lwy_nxt = (s2 > 49'(WY_MAX)) ? WY_MAX :
                    (s2 < 49'(WY_MIN)) ? WY_MIN : s2[47:0];
        end
        if (pos_r < CNT_MAX) pos_nxt = pos_r + CNT_ONE;
        prev_nxt = item_r.feature_value;
        if (item_r.last) begin
          lw_nxt = '0; lwy_nxt = '0; pos_nxt = '0; prev_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        // hold while the previous result beat is still waiting
        if (!ov_r || out_ch.ready) begin
          if (!found_r) begin
            out_nxt = '0;
            out_nxt.is_leaf = 1'b1;
            out_nxt.left_value = (tw_r == 0) ? 16'sd0 : lm_r;
          end else begin
            out_nxt.is_leaf = 1'b0;
            out_nxt.split_feature = bfeat_r;
            out_nxt.split_threshold = bthr_r;
            out_nxt.left_value = blm_r;
            out_nxt.right_value = brm_r;
            out_nxt.left_count = 17'(blc_r);
            out_nxt.right_count = (tc_r > blc_r) ? 17'(tc_r - blc_r) : 17'd0;
            out_nxt.gain = (best_score_r > {1'b0, node_score_r}) ?
                           63'(best_score_r - {1'b0, node_score_r}) : '0;
          end
          ov_nxt = 1'b1;
          tw_nxt = '0; twy_nxt = '0; tc_nxt = '0; node_score_nxt = '0;
          best_score_nxt = '0; found_nxt = 1'b0; bfeat_nxt = '0; bthr_nxt = '0;
          blm_nxt = '0; brm_nxt = '0; blc_nxt = '0;
          lw_nxt = '0; lwy_nxt = '0; pos_nxt = '0; prev_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; acc_r <= acc_nxt; sq_r <= sq_nxt;
    mag_r <= mag_nxt; dw_r <= dw_nxt; dwy_r <= dwy_nxt; lm_r <= lm_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE; sel_r <= '0; sqc_r <= '0; ov_r <= 1'b0;
      tw_r <= '0; twy_r <= '0; tc_r <= '0; node_score_r <= '0;
      best_score_r <= '0; found_r <= 1'b0; bfeat_r <= '0; bthr_r <= '0;
      blm_r <= '0; brm_r <= '0; blc_r <= '0;
      lw_r <= '0; lwy_r <= '0; pos_r <= '0; prev_r <= '0;
    end else begin
      state_r <= state_nxt; sel_r <= sel_nxt; sqc_r <= sqc_nxt; ov_r <= ov_nxt;
      tw_r <= tw_nxt; twy_r <= twy_nxt; tc_r <= tc_nxt;
      node_score_r <= node_score_nxt; best_score_r <= best_score_nxt;
      found_r <= found_nxt; bfeat_r <= bfeat_nxt; bthr_r <= bthr_nxt;
      blm_r <= blm_nxt; brm_r <= brm_nxt; blc_r <= blc_nxt;
      lw_r <= lw_nxt; lwy_r <= lwy_nxt; pos_r <= pos_nxt; prev_r <= prev_nxt;
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for regression_tree_split_search. Random tree nodes are
// streamed as a totals pass, a few sorted feature scans and an emit. A local
// fixed-point model predicts every split or leaf result. Several config
// settings and several idle/stall patterns are used on both channels.
//------------------------------------------------------------------------------
module testbench;
  import rtss_pkg::*;

  localparam longint unsigned SCORE_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint WY_HI = 64'sd140737488355327;
  localparam longint WY_LO = -64'sd140737488355328;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned DRAIN_WAIT = 1200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rtss_if #(.payload_t(in_item_t))  in_ch();
  rtss_if #(.payload_t(out_item_t)) out_ch();

  regression_tree_split_search dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  in_item_t  pending_beats[$];
  out_item_t expected_nodes[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned errors, beats_in, results_seen, splits_seen, cycles;
  bit in_taken;

  // model state
  logic [15:0] min_size;
  logic [31:0] min_weight;
  longint unsigned tot_w, node_score, best_score, run_w;
  longint tot_wy, run_wy, prev_x, best_thr, best_lmean, best_rmean;
  int unsigned tot_cnt, best_lcnt, scan_pos;
  bit found;
  logic [7:0] best_feat;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat48(longint v);
    if (v > WY_HI) return WY_HI;
    if (v < WY_LO) return WY_LO;
    return v;
  endfunction

  function automatic longint unsigned sq_over(longint v, longint unsigned w);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    q = (mag * mag) / 128'(w);
    return (q > 128'(SCORE_LIM)) ? SCORE_LIM : q[63:0];
  endfunction

  function automatic longint round_mean(longint wy, longint unsigned w);
    longint den, num, q;
    den = longint'(w) * 2;
    num = wy * 2 + longint'(w);
    q = (num >= 0) ? num / den : -((-num + den - 1) / den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  task automatic clear_node();
    tot_w = 0; tot_wy = 0; tot_cnt = 0; node_score = 0; best_score = 0;
    found = 0; best_feat = 0; best_thr = 0; best_lmean = 0; best_rmean = 0;
    best_lcnt = 0; run_w = 0; run_wy = 0; scan_pos = 0; prev_x = 0;
  endtask

  task automatic consider_split(logic [7:0] feat, longint x);
    longint unsigned rw, score;
    longint rwy, s, mid;
    if (run_w == 0 || run_w >= tot_w) return;
    rw = tot_w - run_w;
    rwy = tot_wy - run_wy;
    score = sq_over(run_wy, run_w) + sq_over(rwy, rw);
    if (score <= best_score) return;
    if (scan_pos < min_size || scan_pos + min_size > tot_cnt) return;
    if (run_w < min_weight || rw < min_weight) return;
    s = prev_x + x;
    mid = (s >= 0) ? s / 2 : -((-s + 1) / 2);
    if (mid == prev_x) return;
    found = 1; best_score = score; best_feat = feat; best_thr = mid;
    best_lmean = round_mean(run_wy, run_w);
    best_rmean = round_mean(rwy, rw);
    best_lcnt = scan_pos;
  endtask

  task automatic predict_beat(in_item_t it);
    longint wy, x;
    out_item_t r;
    wy = longint'(it.weight) * longint'(it.target);
    x = longint'(it.feature_value);
    case (op_t'(it.operation))
      OP_TOTALS: begin
        tot_w += it.weight;
        if (tot_w > 64'hFFFF_FFFF) tot_w = 64'hFFFF_FFFF;
        tot_wy = sat48(tot_wy + wy);
        if (tot_cnt < MAX_SAMPLES_DEF) tot_cnt++;
        if (it.last) begin
          node_score = (tot_w == 0) ? 0 : sq_over(tot_wy, tot_w);
          best_score = node_score;
          found = 0;
        end
      end
      OP_SCAN: begin
        if (tot_w != 0 && scan_pos > 0) consider_split(it.feature_index, x);
        run_w += it.weight;
        if (run_w > 64'hFFFF_FFFF) run_w = 64'hFFFF_FFFF;
        run_wy = sat48(run_wy + wy);
        if (scan_pos < MAX_SAMPLES_DEF) scan_pos++;
        prev_x = x;
        if (it.last) begin
          run_w = 0; run_wy = 0; scan_pos = 0; prev_x = 0;
        end
      end
      OP_EMIT: begin
        r = '0;
        if (!found) begin
          r.is_leaf = 1'b1;
          r.left_value = (tot_w == 0) ? 16'sd0 : 16'(round_mean(tot_wy, tot_w));
        end else begin
          r.split_feature = best_feat;
          r.split_threshold = 32'(best_thr);
          r.left_value = 16'(best_lmean);
          r.right_value = 16'(best_rmean);
          r.left_count = 17'(best_lcnt);
          r.right_count = (tot_cnt > best_lcnt) ? 17'(tot_cnt - best_lcnt) : 17'd0;
          r.gain = (best_score > node_score) ? 63'(best_score - node_score) : 63'd0;
        end
        expected_nodes.push_back(r);
        clear_node();
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    in_item_t nxt;
    logic nv;
    if (rst_n) begin
      nv = in_ch.valid;
      nxt = in_ch.data;
      if (!in_ch.valid || in_taken) begin
        nv = 1'b0;
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
      in_ch.data <= nxt;
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want, got;
    cycles++;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end else if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        beats_in++;
        predict_beat(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (!got.is_leaf) splits_seen++;
        if (expected_nodes.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_nodes.pop_front();
          if (got.is_leaf !== want.is_leaf) report_mismatch("is_leaf", got.is_leaf, want.is_leaf);
          if (got.split_feature !== want.split_feature)
            report_mismatch("split_feature", got.split_feature, want.split_feature);
          if (got.split_threshold !== want.split_threshold)
            report_mismatch("split_threshold", got.split_threshold, want.split_threshold);
          if (got.left_value !== want.left_value)
            report_mismatch("left_value", got.left_value, want.left_value);
          if (got.right_value !== want.right_value)
            report_mismatch("right_value", got.right_value, want.right_value);
          if (got.left_count !== want.left_count)
            report_mismatch("left_count", got.left_count, want.left_count);
          if (got.right_count !== want.right_count)
            report_mismatch("right_count", got.right_count, want.right_count);
          if (got.gain !== want.gain) report_mismatch("gain", got.gain, want.gain);
        end
      end
    end
  end

  function automatic in_item_t mk_beat(op_t op, logic [7:0] f, logic [15:0] w,
                                       logic [15:0] y, logic [31:0] x, bit last);
    in_item_t b;
    b.operation = op; b.feature_index = f; b.weight = w;
    b.target = y; b.feature_value = x; b.last = last;
    return b;
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_target();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // totals pass, a few sorted scans, then emit
  task automatic queue_node();
    int n, nscan, len, mode;
    logic [15:0] ws[$];
    logic [15:0] ys[$];
    int xs[$];
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(2, 8);
    ws.delete(); ys.delete();
    for (int i = 0; i < n; i++) begin
      ws.push_back(rand_weight());
      ys.push_back(rand_target());
      pending_beats.push_back(mk_beat(OP_TOTALS, 8'($urandom), ws[i], ys[i],
                                      32'($urandom), i == n - 1));
    end
    nscan = $urandom_range(1, 3);
    for (int s = 0; s < nscan; s++) begin
      len = n;
      if ($urandom_range(9) == 0) len = n + 1;
      else if ($urandom_range(9) == 0) len = n - 1;
      mode = $urandom_range(2);
      xs.delete();
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: xs.push_back(int'($urandom_range(0, 7)) - 3);
          1: xs.push_back(int'($urandom));
          default: xs.push_back(int'($urandom_range(0, 1000)) + 32'h7FFF_FC00);
        endcase
      end
      if (mode == 2 && $urandom_range(1)) foreach (xs[i]) xs[i] = -xs[i] - 1;
      xs.sort();
      for (int i = 0; i < len; i++)
        pending_beats.push_back(mk_beat(OP_SCAN, 8'($urandom), ws[i % n], ys[i % n],
                                        xs[i], i == len - 1));
    end
    pending_beats.push_back(mk_beat(OP_EMIT, 8'($urandom), 16'($urandom),
                                    16'($urandom), 32'($urandom), $urandom_range(1)));
  endtask

  task automatic queue_noise();
    pending_beats.push_back(mk_beat(op_t'($urandom_range(3)), 8'($urandom),
                                    16'($urandom), 16'($urandom), 32'($urandom),
                                    $urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || expected_nodes.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_NODE_SIZE) min_size = val[15:0];
    else min_weight = val;
  endtask

  initial begin
    int unsigned sizes[8];
    logic [31:0] wts[8];
    int unsigned idles[4];
    int unsigned stalls[4];
    sizes = '{1, 2, 32768, 1, 3, 1, 2, 1};
    wts = '{0, 0, 0, 32'hFFFF_FFFF, 0, 32'h0000_8000, 32'h0001_0000, 0};
    idles = '{0, 81, 0, 26};
    stalls = '{0, 0, 81, 26};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    errors = 0; beats_in = 0; results_seen = 0; splits_seen = 0; cycles = 0;
    in_taken = 1'b0;
    min_size = 16'd1; min_weight = 32'd0;
    clear_node();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, ignored opcode, empty and zero-weight nodes
    pending_beats.push_back(mk_beat(OP_EMIT, 8'h00, 16'h0, 16'h0, 32'h0, 1'b0));
    pending_beats.push_back(mk_beat(OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    pending_beats.push_back(mk_beat(OP_TOTALS, 8'h00, 16'h0, 16'h7FFF, 32'h0, 1'b1));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'h01, 16'h0, 16'h7FFF, 32'h8000_0000, 1'b0));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'h01, 16'h0, 16'h7FFF, 32'h7FFF_FFFF, 1'b1));
    pending_beats.push_back(mk_beat(OP_EMIT, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    pending_beats.push_back(mk_beat(OP_TOTALS, 8'h00, 16'hFFFF, 16'h8000, 32'h0, 1'b0));
    pending_beats.push_back(mk_beat(OP_TOTALS, 8'h00, 16'hFFFF, 16'h7FFF, 32'h0, 1'b0));
    pending_beats.push_back(mk_beat(OP_TOTALS, 8'h00, 16'h0001, 16'h8000, 32'h0, 1'b1));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'hFF, 16'hFFFF, 16'h8000, 32'h8000_0000, 1'b0));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'hFF, 16'hFFFF, 16'h7FFF, 32'h8000_0001, 1'b0));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'hFF, 16'h0001, 16'h8000, 32'h7FFF_FFFF, 1'b0));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'hFF, 16'h0001, 16'h8000, 32'h7FFF_FFFF, 1'b1));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'h00, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF, 1'b0));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'h00, 16'hFFFF, 16'h7FFF, 32'h0000_0000, 1'b0));
    pending_beats.push_back(mk_beat(OP_SCAN, 8'h00, 16'h0001, 16'h8000, 32'h0000_0001, 1'b1));
    pending_beats.push_back(mk_beat(OP_TOTALS, 8'h00, 16'h0010, 16'h0100, 32'h0, 1'b1));
    pending_beats.push_back(mk_beat(OP_EMIT, 8'h00, 16'h0, 16'h0, 32'h0, 1'b0));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_MIN_NODE_SIZE, sizes[ph]);
      write_cfg(CFG_MIN_NODE_WEIGHT, wts[ph]);
      send_idle_pct = idles[ph % 4];
      recv_stall_pct = stalls[ph % 4];
      while (pending_beats.size() < 230) begin
        if ($urandom_range(9) == 0) queue_noise();
        else queue_node();
      end
      wait_drained();
    end

    $display("%0d input beats accepted, %0d results checked (%0d splits, %0d leaves)",
             beats_in, results_seen, splits_seen, results_seen - splits_seen);
    $display("8 config settings, idle/stall mixes on both channels, %0d errors", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rtss_pkg.sv
hdl/rtss_if.sv
hdl/rtss_div.sv
hdl/regression_tree_split_search.sv
test/testbench.sv
